// ===== rtl/gcdr_pkg.sv =====
`default_nettype none

package gcdr_pkg;

    // Default coordinate width; the top level hands its own value down.
    localparam int COORD_BITS_DEF = 16;

    // Step counter of the microsequencer.
    localparam int PC_W = 4;

    // Datapath operations, one per control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD,      // take the input word, form difference magnitudes and signs
        OP_DIV_GCD,   // start a / b
        OP_DIV_QX,    // start |dx| / g
        OP_DIV_QY,    // start |dy| / g
        OP_DIV_STEP,  // one restoring divide step
        OP_GCD_SWAP,  // a <= b, b <= remainder
        OP_ST_QX,
        OP_ST_QY,
        OP_CLR_Q,
        OP_EMIT       // load the output register
    } op_t;

    // Jump conditions: jump to target when true, else fall through.
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_ZERO_VEC,
        COND_B_ZERO,
        COND_DIV_BUSY,
        COND_OUT_FULL
    } cond_t;

    typedef struct packed {
        op_t              op;
        cond_t            cond;
        logic [PC_W-1:0]  target;
    } ctrl_t;

    // Program step labels.
    localparam logic [PC_W-1:0] PC_IDLE     = PC_W'(0);
    localparam logic [PC_W-1:0] PC_CHK_ZERO = PC_W'(1);
    localparam logic [PC_W-1:0] PC_GCD_TEST = PC_W'(2);
    localparam logic [PC_W-1:0] PC_GCD_DIV  = PC_W'(3);
    localparam logic [PC_W-1:0] PC_GCD_RUN  = PC_W'(4);
    localparam logic [PC_W-1:0] PC_GCD_SWAP = PC_W'(5);
    localparam logic [PC_W-1:0] PC_QX_DIV   = PC_W'(6);
    localparam logic [PC_W-1:0] PC_QX_RUN   = PC_W'(7);
    localparam logic [PC_W-1:0] PC_QX_ST    = PC_W'(8);
    localparam logic [PC_W-1:0] PC_QY_DIV   = PC_W'(9);
    localparam logic [PC_W-1:0] PC_QY_RUN   = PC_W'(10);
    localparam logic [PC_W-1:0] PC_QY_ST    = PC_W'(11);
    localparam logic [PC_W-1:0] PC_ZERO     = PC_W'(12);
    localparam logic [PC_W-1:0] PC_EMIT     = PC_W'(13);
    localparam logic [PC_W-1:0] PC_RETURN   = PC_W'(14);

    // Microcode ROM.
    function automatic ctrl_t ucode_rom(input logic [PC_W-1:0] pc);
        ctrl_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: PC_IDLE};
        case (pc)
            PC_IDLE:     w = '{op: OP_LOAD,     cond: COND_NO_INPUT, target: PC_IDLE};
            PC_CHK_ZERO: w = '{op: OP_NOP,      cond: COND_ZERO_VEC, target: PC_ZERO};
            PC_GCD_TEST: w = '{op: OP_NOP,      cond: COND_B_ZERO,   target: PC_QX_DIV};
            PC_GCD_DIV:  w = '{op: OP_DIV_GCD,  cond: COND_NEVER,    target: PC_IDLE};
            PC_GCD_RUN:  w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: PC_GCD_RUN};
            PC_GCD_SWAP: w = '{op: OP_GCD_SWAP, cond: COND_ALWAYS,   target: PC_GCD_TEST};
            PC_QX_DIV:   w = '{op: OP_DIV_QX,   cond: COND_NEVER,    target: PC_IDLE};
            PC_QX_RUN:   w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: PC_QX_RUN};
            PC_QX_ST:    w = '{op: OP_ST_QX,    cond: COND_NEVER,    target: PC_IDLE};
            PC_QY_DIV:   w = '{op: OP_DIV_QY,   cond: COND_NEVER,    target: PC_IDLE};
            PC_QY_RUN:   w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: PC_QY_RUN};
            PC_QY_ST:    w = '{op: OP_ST_QY,    cond: COND_ALWAYS,   target: PC_EMIT};
            PC_ZERO:     w = '{op: OP_CLR_Q,    cond: COND_NEVER,    target: PC_IDLE};
            PC_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_FULL, target: PC_EMIT};
            PC_RETURN:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE};
            default:     w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/gcdr_in_if.sv =====
`default_nettype none

interface gcdr_in_if
    import gcdr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] src_x;
    logic signed [COORD_BITS-1:0] src_y;
    logic signed [COORD_BITS-1:0] dst_x;
    logic signed [COORD_BITS-1:0] dst_y;

    modport source (output valid, output src_x, output src_y, output dst_x, output dst_y,
                    input ready);
    modport sink   (input valid, input src_x, input src_y, input dst_x, input dst_y,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/gcdr_out_if.sv =====
`default_nettype none

interface gcdr_out_if
    import gcdr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
);
    logic                       valid;
    logic                       ready;
    logic signed [COORD_BITS:0] step_x;
    logic signed [COORD_BITS:0] step_y;
    logic                       zero_vector;

    modport source (output valid, output step_x, output step_y, output zero_vector,
                    input ready);
    modport sink   (input valid, input step_x, input step_y, input zero_vector,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/gcd_reduced_direction_vector_unit.sv =====
`default_nettype none

// Reduces the vector from a source point to a target point to its smallest
// integer step: step = (dst - src) / g, where g is the gcd of the two
// component magnitudes, found by Euclid's algorithm. The divisor is always a
// magnitude, so the step keeps the direction of the difference vector; when
// source equals target the word carries step (0,0) with zero_vector set, and
// when one axis is zero the other axis steps by +1 or -1. One input word gives
// exactly one output word. Each word runs through a microcoded sequencer that
// drives a single shared restoring divider (one quotient bit per cycle). The
// number K of Euclid remainder steps per word is at most about 1.44 *
// COORD_BITS, and is 0 when the y difference is zero. The divider is the
// limit on throughput. A new word is taken only while the sequencer sits in
// its idle step; a finished word waits in the output register, so the next
// word can be accepted and worked on while the sink stalls.
module gcd_reduced_direction_vector_unit
    import gcdr_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)(
    input  wire logic     clk,
    input  wire logic     rst_n,
    gcdr_in_if.sink       in_ch,
    gcdr_out_if.source    out_ch
);

    localparam int MAG_W = COORD_BITS;           // |dst - src| <= 2^N - 1
    localparam int CNT_W = $clog2(COORD_BITS + 1);

    // Sequencer
    logic [PC_W-1:0]  pc_reg, pc_next;
    ctrl_t            ctrl;
    logic             jump;

    // Control registers
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;

    // Datapath registers
    logic [MAG_W-1:0] ax_reg, ax_next, ay_reg, ay_next;
    logic             sx_reg, sx_next, sy_reg, sy_next;
    logic             zero_reg, zero_next;
    logic [MAG_W-1:0] a_reg, a_next, b_reg, b_next;
    logic [MAG_W-1:0] rem_reg, rem_next;
    logic [MAG_W-1:0] dvd_reg, dvd_next;
    logic [MAG_W-1:0] dvs_reg, dvs_next;
    logic [MAG_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic signed [COORD_BITS:0] step_x_reg, step_x_next, step_y_reg, step_y_next;
    logic             zv_reg, zv_next;

    // Combinational helpers
    logic signed [COORD_BITS:0] diff_x, diff_y;
    logic [COORD_BITS:0]        abs_x, abs_y;
    logic [MAG_W:0]             rem_shift;
    logic                       rem_ge;
    logic [MAG_W:0]             rem_sub;
    logic                       out_full;

    assign ctrl     = ucode_rom(pc_reg);
    assign out_full = out_valid_reg && !out_ch.ready;

    // Input handshake is open only on the load step
    assign in_ch.ready = (ctrl.op == OP_LOAD);

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.step_x      = step_x_reg;
    assign out_ch.step_y      = step_y_reg;
    assign out_ch.zero_vector = zv_reg;

    // Difference vector, one bit wider than a coordinate
    assign diff_x = $signed({in_ch.dst_x[COORD_BITS-1], in_ch.dst_x})
                  - $signed({in_ch.src_x[COORD_BITS-1], in_ch.src_x});
    assign diff_y = $signed({in_ch.dst_y[COORD_BITS-1], in_ch.dst_y})
                  - $signed({in_ch.src_y[COORD_BITS-1], in_ch.src_y});
    assign abs_x  = diff_x[COORD_BITS] ? (~diff_x + 1'b1) : diff_x;
    assign abs_y  = diff_y[COORD_BITS] ? (~diff_y + 1'b1) : diff_y;

    // Restoring divide step: shift in the next dividend bit, subtract if it fits
    assign rem_shift = {rem_reg, dvd_reg[MAG_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});
    assign rem_sub   = rem_shift - {1'b0, dvs_reg};

    // Next step: jump on condition, else fall through
    always_comb
    begin
        case (ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_INPUT: jump = !in_ch.valid;
            COND_ZERO_VEC: jump = zero_reg;
            COND_B_ZERO:   jump = (b_reg == '0);
            COND_DIV_BUSY: jump = (cnt_reg != CNT_W'(1));
            COND_OUT_FULL: jump = out_full;
            default:       jump = 1'b1;
        endcase
        pc_next = jump ? ctrl.target : pc_reg + 1'b1;
    end

    // Datapath actions under the current control word
    always_comb
    begin
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        zero_next      = zero_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        rem_next       = rem_reg;
        dvd_next       = dvd_reg;
        dvs_next       = dvs_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        step_x_next    = step_x_reg;
        step_y_next    = step_y_reg;
        zv_next        = zv_reg;

        // Drop the held word once the sink takes it
        if (out_valid_reg && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (ctrl.op)
            OP_LOAD:
            begin
                if (in_ch.valid)
                begin
                    ax_next   = abs_x[MAG_W-1:0];
                    ay_next   = abs_y[MAG_W-1:0];
                    sx_next   = diff_x[COORD_BITS];
                    sy_next   = diff_y[COORD_BITS];
                    zero_next = (diff_x == '0) && (diff_y == '0);
                    a_next    = abs_x[MAG_W-1:0];
                    b_next    = abs_y[MAG_W-1:0];
                end
            end
            OP_DIV_GCD:
            begin
                rem_next = '0;
                dvd_next = a_reg;
                dvs_next = b_reg;
                cnt_next = CNT_W'(COORD_BITS);
            end
            OP_DIV_QX:
            begin
                rem_next = '0;
                dvd_next = ax_reg;
                dvs_next = a_reg;
                cnt_next = CNT_W'(COORD_BITS);
            end
            OP_DIV_QY:
            begin
                rem_next = '0;
                dvd_next = ay_reg;
                dvs_next = a_reg;
                cnt_next = CNT_W'(COORD_BITS);
            end
            OP_DIV_STEP:
            begin
                rem_next = rem_ge ? rem_sub[MAG_W-1:0] : rem_shift[MAG_W-1:0];
                dvd_next = {dvd_reg[MAG_W-2:0], rem_ge};
                cnt_next = cnt_reg - 1'b1;
            end
            OP_GCD_SWAP:
            begin
                a_next = b_reg;
                b_next = rem_reg;
            end
            OP_ST_QX:
            begin
                qx_next = dvd_reg;
            end
            OP_ST_QY:
            begin
                qy_next = dvd_reg;
            end
            OP_CLR_Q:
            begin
                qx_next = '0;
                qy_next = '0;
            end
            OP_EMIT:
            begin
                if (!out_full)
                begin
                    out_valid_next = 1'b1;
                    step_x_next    = sx_reg ? -$signed({1'b0, qx_reg})
                                            :  $signed({1'b0, qx_reg});
                    step_y_next    = sy_reg ? -$signed({1'b0, qy_reg})
                                            :  $signed({1'b0, qy_reg});
                    zv_next        = zero_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= PC_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        sx_reg     <= sx_next;
        sy_reg     <= sy_next;
        zero_reg   <= zero_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        rem_reg    <= rem_next;
        dvd_reg    <= dvd_next;
        dvs_reg    <= dvs_next;
        qx_reg     <= qx_next;
        qy_reg     <= qy_next;
        step_x_reg <= step_x_next;
        step_y_reg <= step_y_next;
        zv_reg     <= zv_next;
    end

    // Assertions

    // An accepted word moves the sequencer straight to the zero check
    a_accept_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (pc_reg == PC_CHK_ZERO))
        else $error("sequencer did not advance after accepting a word");

    // Euclid division never starts with a zero divisor
    a_gcd_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_GCD_DIV) |-> (b_reg != '0))
        else $error("gcd division started with zero divisor");

    // Final divisions use a nonzero gcd
    a_quot_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ((pc_reg == PC_QX_DIV) || (pc_reg == PC_QY_DIV)) |-> (a_reg != '0))
        else $error("quotient division started with zero gcd");

    // A finished remainder is below its divisor
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == PC_GCD_SWAP) |-> (rem_reg < b_reg))
        else $error("remainder not below divisor");

    // A zero-vector word carries zero steps
    a_zero_word_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && zv_reg) |-> ((step_x_reg == '0) && (step_y_reg == '0)))
        else $error("zero vector word with nonzero step");

endmodule

`default_nettype wire
